@@ rtl/gem_pkg.sv @@
package gem_pkg;

    // default sizes handed to the top level
    localparam int GEM_MAX_WIDTH  = 1024;
    localparam int GEM_MAX_HEIGHT = 1024;
    localparam int GEM_PIXEL_BITS = 8;

    // register indexes on the config channel
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CLIP_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_GRAD_MODE    = 2'd3;

    // gradient modes
    localparam logic [1:0] GM_ABS_X = 2'd0;
    localparam logic [1:0] GM_ABS_Y = 2'd1;
    localparam logic [1:0] GM_MAG   = 2'd2;

    // register reset values
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [8:0]  RST_CLIP_LIMIT   = 9'd255;
    localparam logic [1:0]  RST_GRAD_MODE    = GM_MAG;

    // configuration register file
    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [8:0]  clip_limit;
        logic [1:0]  gradient_mode;
    } t_cfg;

    // classification of one queued word
    typedef struct packed {
        logic drain;
        logic has_res;
        logic first_row;
        logic first_col;
        logic last_col;
        logic frame_end;
    } t_cmd;

    localparam int CMD_BITS = $bits(t_cmd);

endpackage

@@ rtl/gem_ram.sv @@
module gem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/gem_queue.sv @@
module gem_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [AW:0]      r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

@@ rtl/gem_front.sv @@
module gem_front import gem_pkg::*; #(
    parameter int MAX_WIDTH  = GEM_MAX_WIDTH,
    parameter int MAX_HEIGHT = GEM_MAX_HEIGHT,
    parameter int PIXEL_BITS = GEM_PIXEL_BITS,
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_accept,
    input  logic                  i_mode,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output logic [CB-1:0]         o_col
);

    logic [WB-1:0] r_col, r_drain;
    logic [HB-1:0] r_row;
    logic [WB-1:0] w, wm1, c, cnt;
    logic [HB-1:0] h, row_inc;
    logic          pending, last;

    // effective frame size, clamped to the supported range
    always_comb begin
        if (i_cfg.frame_width < 11'd2) begin
            w = WB'(2);
        end else if (int'(i_cfg.frame_width) > MAX_WIDTH) begin
            w = WB'(MAX_WIDTH);
        end else begin
            w = WB'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height < 11'd2) begin
            h = HB'(2);
        end else if (int'(i_cfg.frame_height) > MAX_HEIGHT) begin
            h = HB'(MAX_HEIGHT);
        end else begin
            h = HB'(i_cfg.frame_height);
        end
    end

    // classify the word
    assign wm1     = w - WB'(1);
    assign pending = (r_row >= h);
    assign cnt     = i_mode ? r_drain : r_col;
    assign c       = (cnt >= wm1) ? wm1 : cnt;
    assign last    = (c == wm1);
    assign row_inc = r_row + HB'(1);

    always_comb begin
        o_cmd.drain     = i_mode;
        o_cmd.has_res   = i_mode || (r_row != '0);
        o_cmd.first_row = (r_row == HB'(1));
        o_cmd.first_col = (c == '0);
        o_cmd.last_col  = last;
        o_cmd.frame_end = i_mode && last;
    end

    assign o_col  = c[CB-1:0];
    assign o_push = i_accept && (i_mode ? pending : !pending);

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (o_push) begin
            if (!i_mode) begin
                if (last) begin
                    r_col <= '0;
                    if (row_inc >= h) begin
                        r_row   <= h;
                        r_drain <= '0;
                    end else begin
                        r_row <= row_inc;
                    end
                end else begin
                    r_col <= c + WB'(1);
                end
            end else begin
                if (last) begin
                    r_drain <= '0;
                    r_row   <= '0;
                    r_col   <= '0;
                end else begin
                    r_drain <= c + WB'(1);
                end
            end
        end
    end

endmodule

@@ rtl/gem_back.sv @@
module gem_back import gem_pkg::*; #(
    parameter int MAX_WIDTH  = GEM_MAX_WIDTH,
    parameter int PIXEL_BITS = GEM_PIXEL_BITS,
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int P  = PIXEL_BITS,
    localparam int RB = PIXEL_BITS + 1,
    localparam int SB = 2 * PIXEL_BITS + 1,
    localparam int IB = $clog2(RB),
    localparam int VB = (RB + 1 > 9) ? RB + 1 : 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_empty,
    input  t_cmd          i_cmd,
    input  logic [CB-1:0] i_col,
    input  logic [P-1:0]  i_pixel,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [8:0]    o_edge,
    output logic          o_last
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_A0   = 3'd1;
    localparam logic [2:0] B_A1   = 3'd2;
    localparam logic [2:0] B_A2   = 3'd3;
    localparam logic [2:0] B_A3   = 3'd4;
    localparam logic [2:0] B_SUM  = 3'd5;
    localparam logic [2:0] B_SQ   = 3'd6;
    localparam logic [2:0] B_FIN  = 3'd7;

    logic [2:0]    r_state, n_state;
    t_cmd          r_cmd;
    logic [CB-1:0] r_col;
    logic [P-1:0]  r_pix, r_center, r_upo, r_rightn, r_lefto, r_ax, r_ay;
    logic [SB-1:0] r_s;
    logic [RB-1:0] r_root;
    logic [IB-1:0] r_bit;
    logic          r_out_valid, r_last;
    logic [8:0]    r_edge;

    logic [CB-1:0] raddr_new, raddr_old;
    logic [P-1:0]  rdata_new, rdata_old;
    logic          we;
    logic [P-1:0]  left, right, up, down, ax, ay;
    logic [SB-1:0] axe, aye;
    logic [RB-1:0] t;
    logic [2*RB-1:0] te, tsq, se;
    logic [2*RB:0] fe, ff, sf;
    logic [VB-1:0] val, rnd;
    logic          fin_go;

    function automatic logic [P-1:0] absdiff(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // line buffers: previous row and the row before it
    gem_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_col),
        .i_wdata(r_pix),
        .i_raddr(raddr_new),
        .o_rdata(rdata_new)
    );

    gem_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_col),
        .i_wdata(r_center),
        .i_raddr(raddr_old),
        .o_rdata(rdata_old)
    );

    // read address sequence: centre, then right/left, then left of newer row
    always_comb begin
        raddr_new = r_col;
        raddr_old = r_col;
        case (r_state)
            B_A1: begin
                raddr_new = r_col + CB'(1);
                raddr_old = r_col - CB'(1);
            end
            B_A2: begin
                raddr_new = r_col - CB'(1);
            end
            default: begin
                raddr_new = r_col;
                raddr_old = r_col;
            end
        endcase
    end

    assign we = (r_state == B_A3) && !r_cmd.drain;

    // neighbourhood selection with edge clipping
    always_comb begin
        if (r_cmd.drain) begin
            left = r_cmd.first_col ? r_center : rdata_new;
            up   = r_upo;
            down = r_center;
        end else begin
            left = r_cmd.first_col ? r_center : r_lefto;
            up   = r_cmd.first_row ? r_center : r_upo;
            down = r_pix;
        end
        right = r_cmd.last_col ? r_center : r_rightn;
        ax    = absdiff(right, left);
        ay    = absdiff(down, up);
    end

    // squares and one root trial bit
    assign axe = SB'(r_ax);
    assign aye = SB'(r_ay);
    assign t   = r_root | (RB'(1) << r_bit);
    assign te  = (2*RB)'(t);
    assign tsq = te * te;
    assign se  = (2*RB)'(r_s);

    // rounding of the floor root and clipping
    assign fe  = (2*RB+1)'(r_root);
    assign ff  = fe * fe + fe;
    assign sf  = (2*RB+1)'(r_s);
    assign rnd = (sf > ff) ? VB'(r_root) + VB'(1) : VB'(r_root);

    always_comb begin
        case (i_cfg.gradient_mode)
            GM_ABS_X: val = VB'(r_ax);
            GM_ABS_Y: val = VB'(r_ay);
            GM_MAG:   val = rnd;
            default:  val = '0;
        endcase
        if (val > VB'(i_cfg.clip_limit)) begin
            val = VB'(i_cfg.clip_limit);
        end
    end

    assign fin_go = (r_state == B_FIN) && (!r_out_valid || i_ready);
    assign o_pop  = (r_state == B_IDLE) && !i_empty;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_empty) n_state = B_A0;
            B_A0:   n_state = B_A1;
            B_A1:   n_state = B_A2;
            B_A2:   n_state = B_A3;
            B_A3: begin
                if (!r_cmd.has_res) begin
                    n_state = B_IDLE;
                end else if (i_cfg.gradient_mode == GM_MAG) begin
                    n_state = B_SUM;
                end else begin
                    n_state = B_FIN;
                end
            end
            B_SUM:  n_state = B_SQ;
            B_SQ:   if (r_bit == '0) n_state = B_FIN;
            B_FIN:  if (fin_go) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cmd <= i_cmd;
                r_col <= i_col;
                r_pix <= i_pixel;
            end
            B_A1: begin
                r_center <= rdata_new;
                r_upo    <= rdata_old;
            end
            B_A2: begin
                r_rightn <= rdata_new;
                r_lefto  <= rdata_old;
            end
            B_A3: begin
                r_ax <= ax;
                r_ay <= ay;
            end
            B_SUM: begin
                r_s    <= axe * axe + aye * aye;
                r_root <= '0;
                r_bit  <= IB'(RB - 1);
            end
            B_SQ: begin
                if (tsq <= se) begin
                    r_root <= t;
                end
                r_bit <= r_bit - IB'(1);
            end
            default: begin
            end
        endcase
        if (fin_go) begin
            r_edge <= val[8:0];
            r_last <= r_cmd.frame_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_edge  = r_edge;
    assign o_last  = r_last;

endmodule

@@ rtl/gradient_edge_magnitude.sv @@
// Gradient edge magnitude over a raster stream of grayscale pixels.
// Config channel: write i_cfg_data to register i_cfg_index (frame width,
// frame height, clip limit, gradient mode) whenever i_cfg_valid is high;
// o_cfg_ready is always high. Write only while the block is idle.
// Input stream: tdata carries the pixel, tuser selects pixel (0) or drain
// tick (1). Output stream: tdata carries the clipped edge value, tlast
// marks the result of the frame's final pixel.
// A result belongs to the pixel one row above the word that releases it;
// after the last row, one drain tick per pixel flushes that row.
// Each queued word runs through states A0 to A3 (three reads through the
// single read port of each line buffer, then the gradient), in magnitude
// mode through a sum of squares and a root unit that settles one bit per
// cycle, and then waits in FIN to hand over its result. Words of the first
// row end after A3 and produce no result.
// A four-word queue decouples the input from the back end, so input is taken
// while a result waits; when the receiver stalls, the result is held and the
// queue fills, then s_axis_tready drops. Reset restores register defaults and
// clears counters, queue and output; line buffers need no clearing.
module gradient_edge_magnitude import gem_pkg::*; #(
    parameter int MAX_WIDTH  = GEM_MAX_WIDTH,
    parameter int MAX_HEIGHT = GEM_MAX_HEIGHT,
    parameter int PIXEL_BITS = GEM_PIXEL_BITS,
    localparam int DB = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [10:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [DB-1:0] s_axis_tdata,   // pixel
    input  logic          s_axis_tuser,   // mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // edge_value
    output logic          m_axis_tlast
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int QW = CMD_BITS + CB + PIXEL_BITS;

    t_cfg                  r_cfg;
    logic                  push, pop, full, empty, accept;
    t_cmd                  f_cmd, b_cmd;
    logic [CB-1:0]         f_col, b_col;
    logic [PIXEL_BITS-1:0] b_pix;
    logic [QW-1:0]         q_out;
    logic [8:0]            edge_val;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= RST_FRAME_WIDTH;
            r_cfg.frame_height  <= RST_FRAME_HEIGHT;
            r_cfg.clip_limit    <= RST_CLIP_LIMIT;
            r_cfg.gradient_mode <= RST_GRAD_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg.frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg.frame_height  <= i_cfg_data;
                CFG_CLIP_LIMIT:   r_cfg.clip_limit    <= i_cfg_data[8:0];
                CFG_GRAD_MODE:    r_cfg.gradient_mode <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    // front: position tracking and classification
    gem_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_accept(accept),
        .i_mode  (s_axis_tuser),
        .o_push  (push),
        .o_cmd   (f_cmd),
        .o_col   (f_col)
    );

    // queue between front and back
    gem_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_cmd, f_col, s_axis_tdata[PIXEL_BITS-1:0]}),
        .i_pop  (pop),
        .o_data (q_out),
        .o_full (full),
        .o_empty(empty)
    );

    assign {b_cmd, b_col, b_pix} = q_out;

    // back: line buffers, gradient and output register
    gem_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_empty(empty),
        .i_cmd  (b_cmd),
        .i_col  (b_col),
        .i_pixel(b_pix),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_edge (edge_val),
        .o_last (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, edge_val};

endmodule

@@ rtl/gem_checker.sv @@
module gem_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // reset empties the queue, so input is taken at once
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // edge value fits nine bits
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
        else $error("padding bits set");

endmodule

bind gradient_edge_magnitude gem_checker u_gem_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
